// ===== hdl/glt_pkg.sv =====
`default_nettype none
package glt_pkg;

    // defaults for the top-level parameters
    localparam int SLOTS_DEF   = 64;
    localparam int ENT_W_DEF   = 32;
    localparam int GEN_W_DEF   = 16;

    // fixed field widths
    localparam int TYPES       = 8;
    localparam int TYPE_W      = 3;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 3;
    localparam int MASK_W      = 8;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REG_MASK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIER_MASK = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_DALL    = 3'd2,
        CMD_GET     = 3'd3,
        CMD_REACH   = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_UNREG  = 3'd1,
        ST_SELF   = 3'd2,
        ST_DUP    = 3'd3,
        ST_CYCLE  = 3'd4,
        ST_FULL   = 3'd5,
        ST_STALE  = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUP_RD,
        S_DUP_CK,
        S_ALLOC,
        S_A_SLOT,
        S_A_WR,
        S_HND_RD,
        S_HND_CK,
        S_DALL_RD,
        S_DALL_CK,
        S_W_INIT,
        S_W_POP,
        S_W_CUR,
        S_W_RD,
        S_W_CK,
        S_V_RD,
        S_V_CK,
        S_W_PUSH,
        S_W_END,
        S_DONE
    } t_state;

    // write strobes into the slot record memory
    typedef struct packed {
        logic rec_we;
        logic gen_we;
    } t_slot_we;

endpackage
`default_nettype wire

// ===== hdl/generational_link_table.sv =====
`default_nettype none
// generational link table: typed directed links between entity ids
//
// input channel (i_in_valid / o_in_ready) carries one request: a command and
// its operands. output channel (o_out_valid / i_out_ready) returns exactly one
// result per request, in order. configuration is a plain write port: the
// registered-type mask at index 0, the hierarchical-type mask at index 1.
//
// one request at a time, worked by a sequencer around a single-port slot
// memory; each slot visit is a read state and a check state. clear, unused
// commands and unregistered or self-link creates finish at dispatch; get and
// destroy visit the handle's slot; destroy all scans the used slots; create
// scans the used slots for a duplicate, walks for hierarchical types, then
// allocates, reading the generation when a freed slot is reused; reachable
// is a walk. a walk scans the used slots for each popped node and searches
// the visited list for each matching edge.
// o_in_ready is high only while the sequencer is idle, so the next request is
// taken in the cycle after the previous result is registered.
// reset clears alive marks, counts and masks without a memory sweep. a
// stalled receiver holds the result in the output register; one more request
// can be worked and its result waits in the sequencer until the register frees.
module generational_link_table
    import glt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ENT_W = ENT_W_DEF,
    parameter int GEN_W = GEN_W_DEF,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MASK_W-1:0]    i_cfg_data,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [TYPE_W-1:0]    i_link_type,
    input  wire logic [ENT_W-1:0]     i_from_entity,
    input  wire logic [ENT_W-1:0]     i_to_entity,
    input  wire logic [IDX_W-1:0]     i_handle_index,
    input  wire logic [GEN_W-1:0]     i_handle_gen,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [STAT_W-1:0]         o_status,
    output logic [IDX_W-1:0]          o_out_index,
    output logic [GEN_W-1:0]          o_out_gen,
    output logic [TYPE_W-1:0]         o_out_type,
    output logic [ENT_W-1:0]          o_out_from,
    output logic [ENT_W-1:0]          o_out_to,
    output logic                      o_found,
    output logic [CNT_W-1:0]          o_removed_count,
    output logic [CNT_W-1:0]          o_alive_count
);

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // sequencer and table state
    t_state             r_state, n_state;
    logic [MASK_W-1:0]  r_reg_mask, n_reg_mask;
    logic [MASK_W-1:0]  r_hier_mask, n_hier_mask;
    logic [SLOTS-1:0]   r_alive, n_alive;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_fcnt, n_fcnt;
    logic [CNT_W-1:0]   r_live, n_live;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_nf, n_nf;
    logic [CNT_W-1:0]   r_nv, n_nv;
    logic               r_hit, n_hit;

    // captured request
    t_cmd               r_cmd, n_cmd;
    logic [TYPE_W-1:0]  r_type, n_type;
    logic [ENT_W-1:0]   r_from, n_from;
    logic [ENT_W-1:0]   r_to, n_to;
    logic [IDX_W-1:0]   r_hidx, n_hidx;
    logic [GEN_W-1:0]   r_hgen, n_hgen;

    // walk working registers
    logic [ENT_W-1:0]   r_wsrc, n_wsrc;
    logic [ENT_W-1:0]   r_wdst, n_wdst;
    logic [ENT_W-1:0]   r_cur, n_cur;
    logic [ENT_W-1:0]   r_nxt, n_nxt;
    logic [IDX_W-1:0]   r_s, n_s;

    // result being built
    t_status            r_st, n_st;
    logic [IDX_W-1:0]   r_oidx, n_oidx;
    logic [GEN_W-1:0]   r_ogen, n_ogen;
    logic [TYPE_W-1:0]  r_otype, n_otype;
    logic [ENT_W-1:0]   r_ofrom, n_ofrom;
    logic [ENT_W-1:0]   r_oto, n_oto;
    logic               r_ofound, n_ofound;
    logic [CNT_W-1:0]   r_removed, n_removed;

    // output register
    logic               r_ovalid, n_ovalid;
    t_status            r_q_st, n_q_st;
    logic [IDX_W-1:0]   r_q_idx, n_q_idx;
    logic [GEN_W-1:0]   r_q_gen, n_q_gen;
    logic [TYPE_W-1:0]  r_q_type, n_q_type;
    logic [ENT_W-1:0]   r_q_from, n_q_from;
    logic [ENT_W-1:0]   r_q_to, n_q_to;
    logic               r_q_found, n_q_found;
    logic [CNT_W-1:0]   r_q_removed, n_q_removed;
    logic [CNT_W-1:0]   r_q_alive, n_q_alive;

    // slot memory port
    logic [IDX_W-1:0]   slot_addr;
    t_slot_we           slot_we;
    logic [GEN_W-1:0]   slot_wgen;
    logic [TYPE_W-1:0]  sl_type;
    logic [ENT_W-1:0]   sl_src;
    logic [ENT_W-1:0]   sl_tgt;
    logic [GEN_W-1:0]   sl_gen;

    // free stack, frontier and visited memories
    logic [IDX_W-1:0]   r_fstack [SLOTS];
    logic [ENT_W-1:0]   r_front  [SLOTS];
    logic [ENT_W-1:0]   r_visit  [SLOTS];
    logic [IDX_W-1:0]   r_fs_rd;
    logic [ENT_W-1:0]   r_fr_rd;
    logic [ENT_W-1:0]   r_vi_rd;
    logic               fs_we, fr_we, vi_we;
    logic [IDX_W-1:0]   fs_waddr, fs_raddr, fr_waddr, fr_raddr, vi_waddr, vi_raddr;
    logic [IDX_W-1:0]   fs_wdata;
    logic [ENT_W-1:0]   fr_wdata, vi_wdata;

    // kill of one slot, shared by destroy and destroy all
    logic               kill;
    logic [IDX_W-1:0]   kill_idx;

    logic [CNT_W-1:0]   fcnt_m1;
    logic [CNT_W-1:0]   nf_m1;
    logic               type_reg;
    logic               type_hier;

    assign fcnt_m1   = r_fcnt - ONE_C;
    assign nf_m1     = r_nf - ONE_C;
    assign type_reg  = (int'(r_type) < TYPES) && r_reg_mask[r_type];
    assign type_hier = (int'(r_type) < TYPES) && r_hier_mask[r_type];

    glt_slot_ram #(
        .SLOTS (SLOTS),
        .ENT_W (ENT_W),
        .GEN_W (GEN_W)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_addr (slot_addr),
        .i_we   (slot_we),
        .i_type (r_type),
        .i_src  (r_from),
        .i_tgt  (r_to),
        .i_gen  (slot_wgen),
        .o_type (sl_type),
        .o_src  (sl_src),
        .o_tgt  (sl_tgt),
        .o_gen  (sl_gen)
    );

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fstack[fs_waddr] <= fs_wdata;
        end
        if (fr_we) begin
            r_front[fr_waddr] <= fr_wdata;
        end
        if (vi_we) begin
            r_visit[vi_waddr] <= vi_wdata;
        end
        r_fs_rd <= r_fstack[fs_raddr];
        r_fr_rd <= r_front[fr_raddr];
        r_vi_rd <= r_visit[vi_raddr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_mask  <= '0;
            r_hier_mask <= '0;
            r_alive     <= '0;
            r_used      <= '0;
            r_fcnt      <= '0;
            r_live      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_reg_mask  <= n_reg_mask;
            r_hier_mask <= n_hier_mask;
            r_alive     <= n_alive;
            r_used      <= n_used;
            r_fcnt      <= n_fcnt;
            r_live      <= n_live;
            r_ovalid    <= n_ovalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_k         <= n_k;
        r_nf        <= n_nf;
        r_nv        <= n_nv;
        r_hit       <= n_hit;
        r_cmd       <= n_cmd;
        r_type      <= n_type;
        r_from      <= n_from;
        r_to        <= n_to;
        r_hidx      <= n_hidx;
        r_hgen      <= n_hgen;
        r_wsrc      <= n_wsrc;
        r_wdst      <= n_wdst;
        r_cur       <= n_cur;
        r_nxt       <= n_nxt;
        r_s         <= n_s;
        r_st        <= n_st;
        r_oidx      <= n_oidx;
        r_ogen      <= n_ogen;
        r_otype     <= n_otype;
        r_ofrom     <= n_ofrom;
        r_oto       <= n_oto;
        r_ofound    <= n_ofound;
        r_removed   <= n_removed;
        r_q_st      <= n_q_st;
        r_q_idx     <= n_q_idx;
        r_q_gen     <= n_q_gen;
        r_q_type    <= n_q_type;
        r_q_from    <= n_q_from;
        r_q_to      <= n_q_to;
        r_q_found   <= n_q_found;
        r_q_removed <= n_q_removed;
        r_q_alive   <= n_q_alive;
    end

    always_comb begin
        n_state     = r_state;
        n_reg_mask  = r_reg_mask;
        n_hier_mask = r_hier_mask;
        n_alive     = r_alive;
        n_used      = r_used;
        n_fcnt      = r_fcnt;
        n_live      = r_live;
        n_i         = r_i;
        n_k         = r_k;
        n_nf        = r_nf;
        n_nv        = r_nv;
        n_hit       = r_hit;
        n_cmd       = r_cmd;
        n_type      = r_type;
        n_from      = r_from;
        n_to        = r_to;
        n_hidx      = r_hidx;
        n_hgen      = r_hgen;
        n_wsrc      = r_wsrc;
        n_wdst      = r_wdst;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_s         = r_s;
        n_st        = r_st;
        n_oidx      = r_oidx;
        n_ogen      = r_ogen;
        n_otype     = r_otype;
        n_ofrom     = r_ofrom;
        n_oto       = r_oto;
        n_ofound    = r_ofound;
        n_removed   = r_removed;
        n_ovalid    = r_ovalid;
        n_q_st      = r_q_st;
        n_q_idx     = r_q_idx;
        n_q_gen     = r_q_gen;
        n_q_type    = r_q_type;
        n_q_from    = r_q_from;
        n_q_to      = r_q_to;
        n_q_found   = r_q_found;
        n_q_removed = r_q_removed;
        n_q_alive   = r_q_alive;

        slot_addr   = '0;
        slot_we     = '0;
        slot_wgen   = '0;
        fs_we       = 1'b0;
        fs_waddr    = r_fcnt[IDX_W-1:0];
        fs_wdata    = '0;
        fs_raddr    = fcnt_m1[IDX_W-1:0];
        fr_we       = 1'b0;
        fr_waddr    = r_nf[IDX_W-1:0];
        fr_wdata    = r_nxt;
        fr_raddr    = nf_m1[IDX_W-1:0];
        vi_we       = 1'b0;
        vi_waddr    = r_nv[IDX_W-1:0];
        vi_wdata    = r_nxt;
        vi_raddr    = r_k[IDX_W-1:0];
        kill        = 1'b0;
        kill_idx    = r_i[IDX_W-1:0];

        o_in_ready  = (r_state == S_IDLE);

        // receiver took the result
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REG_MASK:  n_reg_mask  = i_cfg_data;
                CFG_HIER_MASK: n_hier_mask = i_cfg_data;
                default:       n_reg_mask  = r_reg_mask;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_type  = i_link_type;
                    n_from  = i_from_entity;
                    n_to    = i_to_entity;
                    n_hidx  = i_handle_index;
                    n_hgen  = i_handle_gen;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_st      = ST_OK;
                n_oidx    = '0;
                n_ogen    = '0;
                n_otype   = '0;
                n_ofrom   = '0;
                n_oto     = '0;
                n_ofound  = 1'b0;
                n_removed = '0;
                n_i       = '0;
                n_state   = S_DONE;
                unique case (r_cmd)
                    CMD_CREATE: begin
                        if (!type_reg) begin
                            n_st = ST_UNREG;
                        end else if (r_from == r_to) begin
                            n_st = ST_SELF;
                        end else begin
                            n_state = S_DUP_RD;
                        end
                    end
                    CMD_DESTROY, CMD_GET: begin
                        n_state = S_HND_RD;
                    end
                    CMD_DALL: begin
                        n_state = S_DALL_RD;
                    end
                    CMD_REACH: begin
                        n_wsrc  = r_from;
                        n_wdst  = r_to;
                        n_state = S_W_INIT;
                    end
                    CMD_CLEAR: begin
                        n_alive = '0;
                        n_used  = '0;
                        n_fcnt  = '0;
                        n_live  = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // duplicate scan over the used slots
            S_DUP_RD: begin
                slot_addr = r_i[IDX_W-1:0];
                if (r_i >= r_used) begin
                    if (type_hier) begin
                        // a cycle exists if the new target already reaches the source
                        n_wsrc  = r_to;
                        n_wdst  = r_from;
                        n_state = S_W_INIT;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    n_state = S_DUP_CK;
                end
            end

            S_DUP_CK: begin
                if (r_alive[r_i[IDX_W-1:0]] && sl_type == r_type &&
                    sl_src == r_from && sl_tgt == r_to) begin
                    n_st    = ST_DUP;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + ONE_C;
                    n_state = S_DUP_RD;
                end
            end

            // slot allocation: free stack first, then append
            S_ALLOC: begin
                if (r_fcnt != '0) begin
                    n_fcnt  = fcnt_m1;
                    n_state = S_A_SLOT;
                end else if (r_used < SLOTS_C) begin
                    slot_addr      = r_used[IDX_W-1:0];
                    slot_we.rec_we = 1'b1;
                    slot_we.gen_we = 1'b1;
                    n_alive[r_used[IDX_W-1:0]] = 1'b1;
                    n_used  = r_used + ONE_C;
                    n_live  = r_live + ONE_C;
                    n_oidx  = r_used[IDX_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end
            end

            S_A_SLOT: begin
                slot_addr = r_fs_rd;
                n_s       = r_fs_rd;
                n_state   = S_A_WR;
            end

            S_A_WR: begin
                slot_addr      = r_s;
                slot_we.rec_we = 1'b1;
                n_alive[r_s]   = 1'b1;
                n_live   = r_live + ONE_C;
                n_oidx   = r_s;
                n_ogen   = sl_gen;
                n_state  = S_DONE;
            end

            // destroy and get by handle
            S_HND_RD: begin
                slot_addr = r_hidx;
                n_state   = S_HND_CK;
            end

            S_HND_CK: begin
                slot_addr = r_hidx;
                kill_idx  = r_hidx;
                n_state   = S_DONE;
                if (CNT_W'(r_hidx) < r_used && r_alive[r_hidx] && sl_gen == r_hgen) begin
                    n_ofound = 1'b1;
                    if (r_cmd == CMD_GET) begin
                        n_otype = sl_type;
                        n_ofrom = sl_src;
                        n_oto   = sl_tgt;
                    end else begin
                        kill = 1'b1;
                    end
                end else begin
                    n_st = ST_STALE;
                end
            end

            // destroy every link touching the entity
            S_DALL_RD: begin
                slot_addr = r_i[IDX_W-1:0];
                if (r_i >= r_used) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DALL_CK;
                end
            end

            S_DALL_CK: begin
                slot_addr = r_i[IDX_W-1:0];
                if (r_alive[r_i[IDX_W-1:0]] && (sl_src == r_from || sl_tgt == r_from)) begin
                    kill      = 1'b1;
                    n_removed = r_removed + ONE_C;
                end
                n_i     = r_i + ONE_C;
                n_state = S_DALL_RD;
            end

            // depth-first walk from r_wsrc looking for r_wdst
            S_W_INIT: begin
                if (r_wsrc == r_wdst) begin
                    n_hit   = 1'b0;
                    n_state = S_W_END;
                end else begin
                    fr_we    = 1'b1;
                    fr_waddr = '0;
                    fr_wdata = r_wsrc;
                    n_nf     = ONE_C;
                    n_nv     = '0;
                    n_state  = S_W_POP;
                end
            end

            S_W_POP: begin
                if (r_nf == '0) begin
                    n_hit   = 1'b0;
                    n_state = S_W_END;
                end else begin
                    n_nf    = nf_m1;
                    n_state = S_W_CUR;
                end
            end

            S_W_CUR: begin
                n_cur   = r_fr_rd;
                n_i     = '0;
                n_state = S_W_RD;
            end

            S_W_RD: begin
                slot_addr = r_i[IDX_W-1:0];
                if (r_i >= r_used) begin
                    n_state = S_W_POP;
                end else begin
                    n_state = S_W_CK;
                end
            end

            S_W_CK: begin
                if (r_alive[r_i[IDX_W-1:0]] && sl_src == r_cur && sl_type == r_type) begin
                    if (sl_tgt == r_wdst) begin
                        n_hit   = 1'b1;
                        n_state = S_W_END;
                    end else begin
                        n_nxt   = sl_tgt;
                        n_k     = '0;
                        n_state = S_V_RD;
                    end
                end else begin
                    n_i     = r_i + ONE_C;
                    n_state = S_W_RD;
                end
            end

            // linear search of the visited list
            S_V_RD: begin
                if (r_k >= r_nv) begin
                    n_state = S_W_PUSH;
                end else begin
                    n_state = S_V_CK;
                end
            end

            S_V_CK: begin
                if (r_vi_rd == r_nxt) begin
                    n_i     = r_i + ONE_C;
                    n_state = S_W_RD;
                end else begin
                    n_k     = r_k + ONE_C;
                    n_state = S_V_RD;
                end
            end

            // pushes beyond a full list are dropped
            S_W_PUSH: begin
                if (r_nv < SLOTS_C) begin
                    vi_we = 1'b1;
                    n_nv  = r_nv + ONE_C;
                end
                if (r_nf < SLOTS_C) begin
                    fr_we = 1'b1;
                    n_nf  = r_nf + ONE_C;
                end
                n_i     = r_i + ONE_C;
                n_state = S_W_RD;
            end

            S_W_END: begin
                if (r_cmd == CMD_CREATE) begin
                    if (r_hit) begin
                        n_st    = ST_CYCLE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    n_ofound = r_hit;
                    n_state  = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid    = 1'b1;
                    n_q_st      = r_st;
                    n_q_idx     = r_oidx;
                    n_q_gen     = r_ogen;
                    n_q_type    = r_otype;
                    n_q_from    = r_ofrom;
                    n_q_to      = r_oto;
                    n_q_found   = r_ofound;
                    n_q_removed = r_removed;
                    n_q_alive   = r_live;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // retire a slot: bump its generation and push it on the free stack
        if (kill) begin
            slot_we.gen_we     = 1'b1;
            slot_wgen          = sl_gen + GEN_W'(1);
            n_alive[kill_idx]  = 1'b0;
            if (r_fcnt < SLOTS_C) begin
                fs_we    = 1'b1;
                fs_wdata = kill_idx;
                n_fcnt   = r_fcnt + ONE_C;
            end
            if (r_live != '0) begin
                n_live = r_live - ONE_C;
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_q_st;
    assign o_out_index     = r_q_idx;
    assign o_out_gen       = r_q_gen;
    assign o_out_type      = r_q_type;
    assign o_out_from      = r_q_from;
    assign o_out_to        = r_q_to;
    assign o_found         = r_q_found;
    assign o_removed_count = r_q_removed;
    assign o_alive_count   = r_q_alive;

endmodule
`default_nettype wire

// ===== hdl/glt_slot_ram.sv =====
`default_nettype none
module glt_slot_ram
    import glt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ENT_W = ENT_W_DEF,
    parameter int GEN_W = GEN_W_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic              i_clk,
    input  wire logic [IDX_W-1:0]  i_addr,
    input  wire t_slot_we          i_we,
    input  wire logic [TYPE_W-1:0] i_type,
    input  wire logic [ENT_W-1:0]  i_src,
    input  wire logic [ENT_W-1:0]  i_tgt,
    input  wire logic [GEN_W-1:0]  i_gen,
    output logic      [TYPE_W-1:0] o_type,
    output logic      [ENT_W-1:0]  o_src,
    output logic      [ENT_W-1:0]  o_tgt,
    output logic      [GEN_W-1:0]  o_gen
);

    localparam int REC_W = TYPE_W + 2 * ENT_W;

    logic [REC_W-1:0] r_rec [SLOTS];
    logic [GEN_W-1:0] r_gen [SLOTS];
    logic [REC_W-1:0] r_rec_q;
    logic [GEN_W-1:0] r_gen_q;

    always_ff @(posedge i_clk) begin
        if (i_we.rec_we) begin
            r_rec[i_addr] <= {i_type, i_src, i_tgt};
        end
        if (i_we.gen_we) begin
            r_gen[i_addr] <= i_gen;
        end
        r_rec_q <= r_rec[i_addr];
        r_gen_q <= r_gen[i_addr];
    end

    assign o_type = r_rec_q[REC_W-1 -: TYPE_W];
    assign o_src  = r_rec_q[2*ENT_W-1 -: ENT_W];
    assign o_tgt  = r_rec_q[ENT_W-1:0];
    assign o_gen  = r_gen_q;

endmodule
`default_nettype wire

// ===== verif/generational_link_table_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module generational_link_table_test;
    import glt_pkg::*;

    localparam int NSLOT   = 64;
    localparam int LIMIT   = 200000;
    localparam logic [2:0] CMD_UNUSED = 3'd6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [MASK_W-1:0]    i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd = '0;
    logic [2:0]  i_link_type = '0;
    logic [31:0] i_from_entity = '0;
    logic [31:0] i_to_entity = '0;
    logic [5:0]  i_handle_index = '0;
    logic [15:0] i_handle_gen = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [5:0]  o_out_index;
    logic [15:0] o_out_gen;
    logic [2:0]  o_out_type;
    logic [31:0] o_out_from;
    logic [31:0] o_out_to;
    logic        o_found;
    logic [6:0]  o_removed_count;
    logic [6:0]  o_alive_count;

    generational_link_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_link_type(i_link_type),
        .i_from_entity(i_from_entity), .i_to_entity(i_to_entity),
        .i_handle_index(i_handle_index), .i_handle_gen(i_handle_gen),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_out_index(o_out_index), .o_out_gen(o_out_gen),
        .o_out_type(o_out_type), .o_out_from(o_out_from), .o_out_to(o_out_to),
        .o_found(o_found), .o_removed_count(o_removed_count),
        .o_alive_count(o_alive_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // one request and one result
    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  ltype;
        logic [31:0] src;
        logic [31:0] dst;
        logic [5:0]  hidx;
        logic [15:0] hgen;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  idx;
        logic [15:0] gen;
        logic [2:0]  ltype;
        logic [31:0] src;
        logic [31:0] dst;
        logic        found;
        logic [6:0]  removed;
        logic [6:0]  alive;
    } t_res;

    // shadow of the link table
    logic [7:0]  reg_mask, hier_mask;
    logic        sh_alive [NSLOT];
    logic [15:0] sh_gen   [NSLOT];
    logic [2:0]  sh_type  [NSLOT];
    logic [31:0] sh_src   [NSLOT];
    logic [31:0] sh_dst   [NSLOT];
    logic [5:0]  free_lifo [$];
    int          used_slots, live_cnt;

    t_res  pending_results [$];
    int    errors = 0;
    int    quiet_cycles = 0;
    int    send_idle_pct = 0, recv_idle_pct = 0;
    bit    hold_off = 1'b0;
    bit    sending = 1'b0;
    // handles of links made so far, to hit live and stale slots
    logic [21:0] known_handles [$];

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            sh_alive[i] = 1'b0;
            sh_gen[i] = '0;
        end
        free_lifo.delete();
        used_slots = 0;
        live_cnt = 0;
    endfunction

    function automatic void unlink(int i);
        sh_alive[i] = 1'b0;
        sh_gen[i] = sh_gen[i] + 16'd1;
        free_lifo.insert(free_lifo.size(), i[5:0]);
        if (live_cnt > 0) live_cnt--;
    endfunction

    // depth-first reachability with bounded frontier and visited list
    function automatic bit reaches(logic [2:0] t, logic [31:0] a, logic [31:0] b);
        logic [31:0] frontier [$];
        logic [31:0] seen_list [$];
        logic [31:0] cur, nxt;
        bit seen;
        if (a == b) return 1'b0;
        frontier.insert(0, a);
        while (frontier.size() > 0) begin
            cur = frontier[$];
            frontier.delete(frontier.size() - 1);
            for (int i = 0; i < used_slots; i++) begin
                if (!sh_alive[i] || sh_src[i] != cur || sh_type[i] != t) continue;
                nxt = sh_dst[i];
                if (nxt == b) return 1'b1;
                seen = 1'b0;
                foreach (seen_list[k]) if (seen_list[k] == nxt) seen = 1'b1;
                if (!seen) begin
                    if (seen_list.size() < NSLOT) seen_list.insert(seen_list.size(), nxt);
                    if (frontier.size() < NSLOT) frontier.insert(frontier.size(), nxt);
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res apply_request(t_req r);
        t_res o;
        int s;
        o = '0;
        case (r.cmd)
            CMD_CREATE: begin
                if (!reg_mask[r.ltype]) o.status = ST_UNREG;
                else if (r.src == r.dst) o.status = ST_SELF;
                else begin
                    for (int i = 0; i < used_slots; i++)
                        if (sh_alive[i] && sh_type[i] == r.ltype && sh_src[i] == r.src
                            && sh_dst[i] == r.dst)
                            o.status = ST_DUP;
                    if (o.status == ST_OK && hier_mask[r.ltype]
                        && reaches(r.ltype, r.dst, r.src))
                        o.status = ST_CYCLE;
                    if (o.status == ST_OK) begin
                        s = -1;
                        if (free_lifo.size() > 0) begin
                            s = free_lifo[$];
                            free_lifo.delete(free_lifo.size() - 1);
                        end else if (used_slots < NSLOT) begin
                            s = used_slots++;
                            sh_gen[s] = '0;
                        end else o.status = ST_FULL;
                        if (s >= 0) begin
                            sh_type[s] = r.ltype;
                            sh_src[s] = r.src;
                            sh_dst[s] = r.dst;
                            sh_alive[s] = 1'b1;
                            live_cnt++;
                            o.idx = s[5:0];
                            o.gen = sh_gen[s];
                            known_handles.insert(known_handles.size(), {o.idx, o.gen});
                        end
                    end
                end
            end
            CMD_DESTROY, CMD_GET: begin
                if (r.hidx < used_slots && sh_alive[r.hidx] && sh_gen[r.hidx] == r.hgen)
                begin
                    o.found = 1'b1;
                    if (r.cmd == CMD_GET) begin
                        o.ltype = sh_type[r.hidx];
                        o.src = sh_src[r.hidx];
                        o.dst = sh_dst[r.hidx];
                    end else unlink(r.hidx);
                end else o.status = ST_STALE;
            end
            CMD_DALL: begin
                for (int i = 0; i < used_slots; i++)
                    if (sh_alive[i] && (sh_src[i] == r.src || sh_dst[i] == r.src)) begin
                        unlink(i);
                        o.removed++;
                    end
            end
            CMD_REACH: o.found = reaches(r.ltype, r.src, r.dst);
            CMD_CLEAR: table_reset();
            default: ;
        endcase
        o.alive = live_cnt[6:0];
        return o;
    endfunction

    // small entity pool so links collide, chain and form cycles
    function automatic logic [31:0] pick_entity();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int k;
        r.cmd = CMD_CREATE;
        r.ltype = $urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 2));
        r.src = pick_entity();
        r.dst = pick_entity();
        r.hidx = 6'($urandom_range(0, 63));
        r.hgen = 16'($urandom());
        k = $urandom_range(0, 99);
        if (k < 45) r.cmd = CMD_CREATE;
        else if (k < 58) r.cmd = CMD_DESTROY;
        else if (k < 64) r.cmd = CMD_DALL;
        else if (k < 80) r.cmd = CMD_GET;
        else if (k < 96) r.cmd = CMD_REACH;
        else if (k < 98) r.cmd = CMD_CLEAR;
        else r.cmd = 3'($urandom_range(6, 7));
        // mostly real handles, some stale ones
        if ((r.cmd == CMD_DESTROY || r.cmd == CMD_GET) && known_handles.size() > 0
            && $urandom_range(0, 9) < 8)
            {r.hidx, r.hgen} = known_handles[$urandom_range(0, known_handles.size() - 1)];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_REG_MASK) reg_mask = val;
        else hier_mask = val;
    endtask

    // hand one request over and record its expected result
    task automatic send_request(t_req r, bit typed, t_res want);
        t_res o;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= r.cmd;
        i_link_type <= r.ltype;
        i_from_entity <= r.src;
        i_to_entity <= r.dst;
        i_handle_index <= r.hidx;
        i_handle_gen <= r.hgen;
        do @(posedge i_clk); while (!o_in_ready);
        o = apply_request(r);
        if (typed && o != want) begin
            $display("%0t typed row disagrees: expected %h predictor %h", $time, want, o);
            errors++;
        end
        pending_results.insert(pending_results.size(), typed ? want : o);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // receiver side with random stalls and a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result compare
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_status, o_out_index, o_out_gen, o_out_type, o_out_from, o_out_to,
                   o_found, o_removed_count, o_alive_count};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.idx != want.idx
                    || got.gen != want.gen || got.ltype != want.ltype
                    || got.src != want.src || got.dst != want.dst
                    || got.found != want.found || got.removed != want.removed
                    || got.alive != want.alive) begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("generational_link_table_test failed");
            $finish;
        end
    end

    // directed rows: cmd, type, from, to, index, gen, typed expectation or not
    typedef struct packed {
        t_req r;
        bit   typed;
        t_res want;
    } t_row;

    t_row rows [$];

    function automatic t_row mk(int c, int t, logic [31:0] a,
                                logic [31:0] b, int hi, int hg,
                                int typed, int st, int alive);
        t_row w;
        w.r = {3'(c), 3'(t), a, b, 6'(hi), 16'(hg)};
        w.typed = (typed != 0);
        w.want = '0;
        w.want.status = 3'(st);
        w.want.alive = 7'(alive);
        return w;
    endfunction

    function automatic void put_row(t_row w);
        rows.insert(rows.size(), w);
    endfunction

    initial begin
        t_req r;
        table_reset();
        reg_mask = '0;
        hier_mask = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing registered yet
        put_row(mk(CMD_CREATE, 7, 32'd1, 32'd2, 0, 0, 1, ST_UNREG, 0));
        put_row(mk(CMD_GET, 0, 0, 0, 0, 0, 1, ST_STALE, 0));
        put_row(mk(CMD_DESTROY, 0, 0, 0, 63, 16'hFFFF, 1, ST_STALE, 0));
        put_row(mk(CMD_UNUSED, 0, 0, 0, 0, 0, 1, ST_OK, 0));
        put_row(mk(7, 0, 0, 0, 0, 0, 1, ST_OK, 0));
        foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].want);
        drain();
        rows.delete();

        write_reg(CFG_REG_MASK, 8'hFF);
        write_reg(CFG_HIER_MASK, 8'h01);
        // self link, chain, duplicate, cycle, walk queries, handles, removal, clear
        put_row(mk(CMD_CREATE, 0, 32'd5, 32'd5, 0, 0, 1, ST_SELF, 0));
        put_row(mk(CMD_CREATE, 0, 32'd1, 32'd2, 0, 0, 0, 0, 0));
        put_row(mk(CMD_CREATE, 0, 32'd2, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        put_row(mk(CMD_CREATE, 0, 32'd1, 32'd2, 0, 0, 1, ST_DUP, 2));
        put_row(mk(CMD_CREATE, 0, 32'hFFFF_FFFF, 32'd1, 0, 0, 1, ST_CYCLE, 2));
        put_row(mk(CMD_CREATE, 1, 32'hFFFF_FFFF, 32'd1, 0, 0, 0, 0, 0));
        put_row(mk(CMD_REACH, 0, 32'd1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        put_row(mk(CMD_REACH, 0, 32'd1, 32'd1, 0, 0, 0, 0, 0));
        put_row(mk(CMD_GET, 0, 0, 0, 1, 0, 0, 0, 0));
        put_row(mk(CMD_DESTROY, 0, 0, 0, 0, 0, 0, 0, 0));
        put_row(mk(CMD_DESTROY, 0, 0, 0, 0, 0, 1, ST_STALE, 2));
        put_row(mk(CMD_CREATE, 2, 32'd0, 32'd9, 0, 0, 0, 0, 0));
        put_row(mk(CMD_DALL, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        put_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_OK, 0));
        foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].want);
        drain();

        // fill the table to full, then churn handles through one slot
        for (int i = 0; i < NSLOT + 2; i++) begin
            r = '0;
            r.cmd = CMD_CREATE;
            r.ltype = 3'd3;
            r.src = i;
            r.dst = i + 1000;
            send_request(r, 1'b0, '0);
        end
        known_handles.delete();
        for (int g = 0; g < 40; g++) begin
            r = '0;
            r.cmd = g[0] ? CMD_CREATE : CMD_DESTROY;
            r.ltype = 3'd3;
            r.src = 32'd7;
            r.dst = 32'd1007;
            r.hidx = 6'd7;
            r.hgen = 16'(g / 2);
            send_request(r, 1'b0, '0);
        end
        r = '0;
        r.cmd = CMD_CLEAR;
        send_request(r, 1'b0, '0);

        // receiver stalls long while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_request(random_request(), 1'b0, '0);
        join
        drain();

        // random phases across several mask settings and idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_REG_MASK, 8'h0F); write_reg(CFG_HIER_MASK, 8'hFF); end
                1: begin write_reg(CFG_REG_MASK, 8'hFF); write_reg(CFG_HIER_MASK, 8'h00); end
                2: begin write_reg(CFG_REG_MASK, 8'h00); write_reg(CFG_HIER_MASK, 8'hAA); end
                3: begin write_reg(CFG_REG_MASK, 8'hFF); write_reg(CFG_HIER_MASK, 8'h55); end
                default: begin
                    write_reg(CFG_REG_MASK, 8'($urandom()));
                    write_reg(CFG_HIER_MASK, 8'($urandom()));
                end
            endcase
            if (ph < 2) begin send_idle_pct = 30; recv_idle_pct = 45; end
            else if (ph < 4) begin send_idle_pct = 45; recv_idle_pct = 30; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int i = 0; i < (ph == 2 ? 50 : 250); i++)
                send_request(random_request(), 1'b0, '0);
            // sender pauses until everything is back
            drain();
        end

        if (errors == 0) $display("generational_link_table_test passed");
        else $display("generational_link_table_test failed");
        $finish;
    end

endmodule
`default_nettype wire
